/* design/db_handshake_field_extractor_unit_defines.svh */
// Assertion macros used by the checker file of the greeting field extractor.
`ifndef DB_HANDSHAKE_FIELD_EXTRACTOR_UNIT_DEFINES_SVH
`define DB_HANDSHAKE_FIELD_EXTRACTOR_UNIT_DEFINES_SVH

// Same-cycle implication, sampled on clk and ignored while rst_n is low.
`define DBFE_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk and ignored while rst_n is low.
`define DBFE_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* design/dbfe_pkg.sv */
package dbfe_pkg;

  localparam int unsigned VERSION_MAX_CHARS_DEF = 127;

  localparam logic [7:0]  GREETING_PROTO = 8'h0a;
  localparam logic [3:0]  CONNID_BYTES   = 4'd4;
  localparam logic [3:0]  SKIP_BYTES     = 4'd9;
  localparam logic [3:0]  CAPS_BYTES     = 4'd2;
  localparam logic [24:0] HEADER_BYTES   = 25'd4;
  localparam logic [15:0] POS_MAX        = 16'hffff;

  localparam logic [15:0] HC_PORT_RST    = 16'd3306;
  localparam logic [15:0] LEN_MARGIN_RST = 16'd32;

  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CFG_DATA_W = 16;
  localparam logic [CFG_IDX_W-1:0] CFG_HC_PORT    = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_LEN_MARGIN = 1'b1;

  localparam logic [2:0] KIND_LENGTH   = 3'd0;
  localparam logic [2:0] KIND_SEQUENCE = 3'd1;
  localparam logic [2:0] KIND_PROTOCOL = 3'd2;
  localparam logic [2:0] KIND_VER_CHAR = 3'd3;
  localparam logic [2:0] KIND_VER_END  = 3'd4;
  localparam logic [2:0] KIND_CONN_ID  = 3'd5;
  localparam logic [2:0] KIND_CAPS     = 3'd6;
  localparam logic [2:0] KIND_VERDICT  = 3'd7;

  localparam logic [31:0] VERDICT_NONE = 32'd0;
  localparam logic [31:0] VERDICT_LOW  = 32'd1;
  localparam logic [31:0] VERDICT_HIGH = 32'd2;

  typedef enum logic [6:0] {
    PH_HEADER  = 7'b0000001,
    PH_PROTO   = 7'b0000010,
    PH_VERSION = 7'b0000100,
    PH_CONNID  = 7'b0001000,
    PH_SKIP    = 7'b0010000,
    PH_CAPS    = 7'b0100000,
    PH_DONE    = 7'b1000000
  } phase_t;

  typedef struct packed {
    logic [2:0]  kind;
    logic [31:0] value;
    logic        last;
  } rec_t;

  typedef struct packed {
    logic v0;
    rec_t r0;
    logic v1;
    rec_t r1;
  } push_t;

  typedef struct packed {
    logic [15:0] hc_port;
    logic [15:0] len_margin;
  } cfg_t;

endpackage

/* design/dbfe_channels.sv */
interface dbfe_in_if;
  logic        valid;
  logic        ready;
  logic [7:0]  data_byte;
  logic        first_byte;
  logic        last_byte;
  logic [15:0] seg_port;
  logic        is_tcp;

  modport source (output valid, data_byte, first_byte, last_byte, seg_port, is_tcp,
                  input ready);
  modport sink (input valid, data_byte, first_byte, last_byte, seg_port, is_tcp,
                output ready);
endinterface

interface dbfe_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  record_kind;
  logic [31:0] record_value;
  logic        last_of_run;

  modport source (output valid, record_kind, record_value, last_of_run, input ready);
  modport sink (input valid, record_kind, record_value, last_of_run, output ready);
endinterface

/* design/dbfe_parse.sv */
module dbfe_parse #(
  parameter int unsigned VERSION_MAX_CHARS = dbfe_pkg::VERSION_MAX_CHARS_DEF
) (
  input  logic           clk,
  input  logic           rst_n,
  dbfe_in_if.sink        in_chan,
  input  dbfe_pkg::cfg_t cfg,
  input  logic           space_ok,
  output dbfe_pkg::push_t push
);
  import dbfe_pkg::*;

  localparam int unsigned CNT_W = $clog2(VERSION_MAX_CHARS + 1);
  localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(VERSION_MAX_CHARS);

  logic        in_valid_r;
  logic        in_valid_nxt;
  logic [7:0]  byte_r;
  logic        first_r;
  logic        last_r;
  logic [15:0] port_in_r;
  logic        tcp_in_r;
  logic        consume;

  logic [15:0]      pos_r, pos_cur, pos_nxt;
  phase_t           phase_r, phase_cur, phase_nxt;
  logic [23:0]      dlen_r, dlen_cur, dlen_nxt;
  logic [7:0]       seq_r, seq_cur, seq_nxt;
  logic             vok_r, vok_cur, vok_nxt;
  logic [CNT_W-1:0] vcnt_r, vcnt_cur, vcnt_nxt;
  logic [3:0]       off_r, off_cur, off_nxt, off_inc;
  logic [31:0]      shift_r, shift_cur, shift_nxt;
  logic [15:0]      lport_r, lport_nxt;
  logic             ltcp_r, ltcp_nxt;

  logic        field_v;
  logic [2:0]  field_kind;
  logic [31:0] field_value;
  logic        len_ok;
  logic [31:0] verdict;
  rec_t        field_rec;
  rec_t        verdict_rec;

  assign consume       = in_valid_r && space_ok;
  assign in_chan.ready = !in_valid_r || space_ok;
  assign in_valid_nxt  = (in_chan.valid && in_chan.ready) || (in_valid_r && !space_ok);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else begin
      in_valid_r <= in_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_chan.valid && in_chan.ready) begin
      byte_r    <= in_chan.data_byte;
      first_r   <= in_chan.first_byte;
      last_r    <= in_chan.last_byte;
      port_in_r <= in_chan.seg_port;
      tcp_in_r  <= in_chan.is_tcp;
    end
  end

  always_comb begin
    pos_cur   = pos_r;
    phase_cur = phase_r;
    dlen_cur  = dlen_r;
    seq_cur   = seq_r;
    vok_cur   = vok_r;
    vcnt_cur  = vcnt_r;
    off_cur   = off_r;
    shift_cur = shift_r;
    lport_nxt = lport_r;
    ltcp_nxt  = ltcp_r;
    if (first_r) begin
      pos_cur   = '0;
      phase_cur = PH_HEADER;
      dlen_cur  = '0;
      seq_cur   = '0;
      vok_cur   = 1'b0;
      vcnt_cur  = '0;
      off_cur   = '0;
      shift_cur = '0;
      lport_nxt = port_in_r;
      ltcp_nxt  = tcp_in_r;
    end

    phase_nxt   = phase_cur;
    dlen_nxt    = dlen_cur;
    seq_nxt     = seq_cur;
    vok_nxt     = vok_cur;
    vcnt_nxt    = vcnt_cur;
    off_nxt     = off_cur;
    shift_nxt   = shift_cur;
    off_inc     = off_cur + 4'd1;
    field_v     = 1'b0;
    field_kind  = KIND_LENGTH;
    field_value = '0;

    case (phase_cur)
      PH_HEADER: begin
        if (pos_cur < 16'd3) begin
          dlen_nxt[{pos_cur[1:0], 3'b000} +: 8] = byte_r;
          if (pos_cur == 16'd2) begin
            field_v     = 1'b1;
            field_kind  = KIND_LENGTH;
            field_value = {8'h00, dlen_nxt};
          end
        end else begin
          seq_nxt     = byte_r;
          field_v     = 1'b1;
          field_kind  = KIND_SEQUENCE;
          field_value = {24'h0, byte_r};
          phase_nxt   = PH_PROTO;
        end
      end
      PH_PROTO: begin
        if (byte_r == GREETING_PROTO) begin
          vok_nxt     = 1'b1;
          field_v     = 1'b1;
          field_kind  = KIND_PROTOCOL;
          field_value = {24'h0, byte_r};
          phase_nxt   = PH_VERSION;
        end else begin
          phase_nxt = PH_DONE;
        end
      end
      PH_VERSION: begin
        if (byte_r == 8'h00) begin
          field_v     = 1'b1;
          field_kind  = KIND_VER_END;
          field_value = 32'(vcnt_cur);
          phase_nxt   = PH_CONNID;
          off_nxt     = '0;
          shift_nxt   = '0;
        end else if (vcnt_cur < CNT_MAX) begin
          field_v     = 1'b1;
          field_kind  = KIND_VER_CHAR;
          field_value = {24'h0, byte_r};
          vcnt_nxt    = vcnt_cur + CNT_W'(1);
        end
      end
      PH_CONNID: begin
        shift_nxt[{off_cur[1:0], 3'b000} +: 8] =
          shift_cur[{off_cur[1:0], 3'b000} +: 8] | byte_r;
        off_nxt = off_inc;
        if (off_inc >= CONNID_BYTES) begin
          field_v     = 1'b1;
          field_kind  = KIND_CONN_ID;
          field_value = shift_nxt;
          phase_nxt   = PH_SKIP;
          off_nxt     = '0;
        end
      end
      PH_SKIP: begin
        off_nxt = off_inc;
        if (off_inc >= SKIP_BYTES) begin
          phase_nxt = PH_CAPS;
          off_nxt   = '0;
          shift_nxt = '0;
        end
      end
      PH_CAPS: begin
        shift_nxt[{1'b0, off_cur[0], 3'b000} +: 8] =
          shift_cur[{1'b0, off_cur[0], 3'b000} +: 8] | byte_r;
        off_nxt = off_inc;
        if (off_inc >= CAPS_BYTES) begin
          field_v     = 1'b1;
          field_kind  = KIND_CAPS;
          field_value = {16'h0, shift_nxt[15:0]};
          phase_nxt   = PH_DONE;
          off_nxt     = '0;
        end
      end
      default: begin
        phase_nxt = phase_cur;
      end
    endcase

    pos_nxt = (pos_cur != POS_MAX) ? pos_cur + 16'd1 : pos_cur;

    len_ok  = ({1'b0, dlen_nxt} + HEADER_BYTES) <= (25'(pos_nxt) + 25'(cfg.len_margin));
    verdict = VERDICT_NONE;
    if (ltcp_nxt && vok_nxt && (seq_nxt == 8'h00) && len_ok) begin
      verdict = (lport_nxt == cfg.hc_port) ? VERDICT_HIGH : VERDICT_LOW;
    end

    field_rec   = '{kind: field_kind, value: field_value, last: !last_r};
    verdict_rec = '{kind: KIND_VERDICT, value: verdict, last: 1'b1};

    if (field_v) begin
      push = '{v0: consume, r0: field_rec, v1: consume && last_r, r1: verdict_rec};
    end else begin
      push = '{v0: consume && last_r, r0: verdict_rec, v1: 1'b0, r1: verdict_rec};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r   <= '0;
      phase_r <= PH_HEADER;
      dlen_r  <= '0;
      seq_r   <= '0;
      vok_r   <= 1'b0;
      vcnt_r  <= '0;
      off_r   <= '0;
      shift_r <= '0;
      lport_r <= '0;
      ltcp_r  <= 1'b0;
    end else if (consume) begin
      pos_r   <= pos_nxt;
      phase_r <= phase_nxt;
      dlen_r  <= dlen_nxt;
      seq_r   <= seq_nxt;
      vok_r   <= vok_nxt;
      vcnt_r  <= vcnt_nxt;
      off_r   <= off_nxt;
      shift_r <= shift_nxt;
      lport_r <= lport_nxt;
      ltcp_r  <= ltcp_nxt;
    end
  end

endmodule

/* design/dbfe_fifo.sv */
module dbfe_fifo (
  input  logic            clk,
  input  logic            rst_n,
  input  dbfe_pkg::push_t push,
  output logic            space_ok,
  dbfe_out_if.source      out_chan
);
  import dbfe_pkg::*;

  rec_t       mem_r [4];
  logic [1:0] wr_ptr_r, wr_ptr_nxt;
  logic [1:0] rd_ptr_r, rd_ptr_nxt;
  logic [2:0] count_r, count_nxt;
  logic       pop;
  logic [2:0] push_n;

  assign space_ok = count_r <= 3'd2;
  assign pop      = out_chan.valid && out_chan.ready;
  assign push_n   = {2'b00, push.v0} + {2'b00, push.v1};

  assign wr_ptr_nxt = wr_ptr_r + push_n[1:0];
  assign rd_ptr_nxt = rd_ptr_r + {1'b0, pop};
  assign count_nxt  = count_r + push_n - {2'b00, pop};

  assign out_chan.valid        = count_r != 3'd0;
  assign out_chan.record_kind  = mem_r[rd_ptr_r].kind;
  assign out_chan.record_value = mem_r[rd_ptr_r].value;
  assign out_chan.last_of_run  = mem_r[rd_ptr_r].last;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push.v0) begin
      mem_r[wr_ptr_r] <= push.r0;
    end
    if (push.v1) begin
      mem_r[wr_ptr_r + 2'd1] <= push.r1;
    end
  end

endmodule

/* design/db_handshake_field_extractor_unit.sv */
// Accepted bytes pass the input register into a four-entry result queue, one byte
// per cycle while the queue has room for two records. A byte that completes a field
// and is also the last byte gives two records, drained one per cycle while out_chan
// is ready. Reset: synchronous on rst_n low; configuration returns to port 3306 and
// margin 32, the parse state clears and the input stage and result queue empty.
module db_handshake_field_extractor_unit #(
  parameter int unsigned VERSION_MAX_CHARS = dbfe_pkg::VERSION_MAX_CHARS_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  dbfe_in_if.sink                        in_chan,
  dbfe_out_if.source                     out_chan,
  input  logic                           cfg_we,
  input  logic [dbfe_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [dbfe_pkg::CFG_DATA_W-1:0] cfg_data
);
  import dbfe_pkg::*;

  cfg_t  cfg_r;
  push_t push;
  logic  space_ok;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.hc_port    <= HC_PORT_RST;
      cfg_r.len_margin <= LEN_MARGIN_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_HC_PORT:    cfg_r.hc_port    <= cfg_data;
        CFG_LEN_MARGIN: cfg_r.len_margin <= cfg_data;
        default:        cfg_r            <= cfg_r;
      endcase
    end
  end

  dbfe_parse #(
    .VERSION_MAX_CHARS(VERSION_MAX_CHARS)
  ) u_parse (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .cfg      (cfg_r),
    .space_ok (space_ok),
    .push     (push)
  );

  dbfe_fifo u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .space_ok (space_ok),
    .out_chan (out_chan)
  );

endmodule

/* design/dbfe_checker.sv */
`include "db_handshake_field_extractor_unit_defines.svh"

module dbfe_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_ready,
  input logic [2:0]  out_kind,
  input logic [31:0] out_value,
  input logic        out_last
);
  import dbfe_pkg::*;

  `DBFE_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_kind) && $stable(out_value) && $stable(out_last), "Stalled result changed or was withdrawn.")

  `DBFE_ASSERT_NOW(a_verdict_last, out_valid && (out_kind == KIND_VERDICT), out_last, "A verdict record must close its run.")

  `DBFE_ASSERT_NOW(a_verdict_code, out_valid && (out_kind == KIND_VERDICT), out_value <= VERDICT_HIGH, "Verdict code out of range.")

  `DBFE_ASSERT_NOW(a_narrow_fields, out_valid && ((out_kind == KIND_LENGTH) || (out_kind == KIND_CAPS)), out_value[31:24] == 8'h00 && (out_kind != KIND_CAPS || out_value[23:16] == 8'h00), "Length or capability record wider than its field.")

endmodule

bind db_handshake_field_extractor_unit dbfe_checker u_dbfe_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_chan.valid),
  .out_ready (out_chan.ready),
  .out_kind  (out_chan.record_kind),
  .out_value (out_chan.record_value),
  .out_last  (out_chan.last_of_run)
);
